// File: rtl/lfpid_pkg.sv
`timescale 1ns / 1ps
package lfpid_pkg;

   localparam int SENSOR_W  = 10;
   localparam int SPEED_W   = 7;
   localparam int GAIN_W    = 16;
   localparam int ERR_W     = 15;
   localparam int SUM_W     = 32;
   localparam int PROD_W    = GAIN_W + SUM_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 4;

   localparam int TICK_PERIOD_DEF  = 66;
   localparam int UPDATE_EVERY_DEF = 10;

   localparam int SPEED_CENTER = 33;
   localparam int PID_LIMIT    = 33;
   localparam int SPEED_MAX    = SPEED_CENTER + PID_LIMIT;
   localparam int ERR_SCALE    = 10240;
   localparam int GAIN_ONE     = 256;

   // denominator 10240 * 256 = 5 * 2^19
   localparam int DEN_SHIFT   = 19;
   localparam int DEN_ODD     = 5;
   localparam int RECIP       = 205;
   localparam int RECIP_W     = 8;
   localparam int RECIP_SHIFT = 10;
   localparam int Y_W         = 9;
   localparam int Y_OFFSET    = PID_LIMIT * DEN_ODD;

   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(PID_LIMIT * ERR_SCALE * GAIN_ONE);
   localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_ACC,
      OP_SCALE,
      OP_SPEED,
      OP_DIV_INIT,
      OP_DIV_ITER,
      OP_DIV_DONE,
      OP_MOD_INIT,
      OP_MOD_ITER,
      OP_DONE
   } op_type;

   typedef enum logic [1:0] {
      J_NEXT,
      J_SKIP,
      J_LOOP,
      J_END
   } jump_type;

   typedef struct packed {
      op_type              op;
      jump_type            jump;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic busy;
      logic fire;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic skip_pid;
      logic loop_more;
      logic out_busy;
   } status_type;

   localparam logic [STEP_W-1:0] ADDR_MUL_P    = 4'd0;
   localparam logic [STEP_W-1:0] ADDR_MUL_I    = 4'd1;
   localparam logic [STEP_W-1:0] ADDR_MUL_D    = 4'd2;
   localparam logic [STEP_W-1:0] ADDR_ACC      = 4'd3;
   localparam logic [STEP_W-1:0] ADDR_SCALE    = 4'd4;
   localparam logic [STEP_W-1:0] ADDR_SPEED    = 4'd5;
   localparam logic [STEP_W-1:0] ADDR_DIV_INIT = 4'd6;
   localparam logic [STEP_W-1:0] ADDR_DIV_ITER = 4'd7;
   localparam logic [STEP_W-1:0] ADDR_DIV_DONE = 4'd8;
   localparam logic [STEP_W-1:0] ADDR_MOD_INIT = 4'd9;
   localparam logic [STEP_W-1:0] ADDR_MOD_ITER = 4'd10;
   localparam logic [STEP_W-1:0] ADDR_DONE     = 4'd11;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      case (addr)
         ADDR_MUL_P:    w = '{op: OP_MUL_P,    jump: J_SKIP, target: ADDR_MOD_INIT};
         ADDR_MUL_I:    w = '{op: OP_MUL_I,    jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_MUL_D:    w = '{op: OP_MUL_D,    jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_ACC:      w = '{op: OP_ACC,      jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_SCALE:    w = '{op: OP_SCALE,    jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_SPEED:    w = '{op: OP_SPEED,    jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_DIV_INIT: w = '{op: OP_DIV_INIT, jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_DIV_ITER: w = '{op: OP_DIV_ITER, jump: J_LOOP, target: ADDR_DIV_ITER};
         ADDR_DIV_DONE: w = '{op: OP_DIV_DONE, jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_MOD_INIT: w = '{op: OP_MOD_INIT, jump: J_NEXT, target: ADDR_MUL_P};
         ADDR_MOD_ITER: w = '{op: OP_MOD_ITER, jump: J_LOOP, target: ADDR_MOD_ITER};
         ADDR_DONE:     w = '{op: OP_DONE,     jump: J_END,  target: ADDR_MUL_P};
         default:       w = '{op: OP_NOP,      jump: J_END,  target: ADDR_MUL_P};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/lfpid_seq.sv
`timescale 1ns / 1ps
module lfpid_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  lfpid_pkg::status_type status,
   output lfpid_pkg::ctrl_type   ctrl
);

   logic                         busy_ff, busy_in;
   logic [lfpid_pkg::STEP_W-1:0] step_ff, step_in;
   logic [lfpid_pkg::STEP_W-1:0] step_next;
   lfpid_pkg::ucode_type         cw;
   logic                         hold;

   assign cw        = lfpid_pkg::ucode_rom(step_ff);
   assign step_next = step_ff + lfpid_pkg::STEP_W'(1);
   assign hold      = (cw.jump == lfpid_pkg::J_END) && status.out_busy;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (status.start) begin
            busy_in = 1'b1;
            step_in = lfpid_pkg::ADDR_MUL_P;
         end
      end else begin
         case (cw.jump)
            lfpid_pkg::J_NEXT: step_in = step_next;
            lfpid_pkg::J_SKIP: step_in = status.skip_pid ? cw.target : step_next;
            lfpid_pkg::J_LOOP: step_in = status.loop_more ? cw.target : step_next;
            lfpid_pkg::J_END: begin
               if (!status.out_busy) begin
                  busy_in = 1'b0;
                  step_in = lfpid_pkg::ADDR_MUL_P;
               end
            end
            default: begin
               busy_in = 1'b0;
               step_in = lfpid_pkg::ADDR_MUL_P;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= lfpid_pkg::ADDR_MUL_P;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl.busy = busy_ff;
   assign ctrl.fire = busy_ff && !hold;
   assign ctrl.op   = cw.op;

endmodule

// File: rtl/lfpid_div_lane.sv
`timescale 1ns / 1ps
module lfpid_div_lane #(
   parameter int NUM_W = 7,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (load) begin
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (step) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/line_follow_pid_stepper_pulser.sv
`timescale 1ns / 1ps
// Line-follower PID with two stepper pulse outputs.
// req_*: one item per timer tick with four 10-bit sensor samples.
// rsp_*: exactly one item per tick: step pulse flags and current speeds.
// csr_*: gain_p, gain_i, gain_d (signed Q8.8) at indexes 0..2; write only
// while idle. Higher indexes are dropped.
// A microcode sequencer steps a shared 16x32 multiplier, an accumulator and
// two restoring divider lanes (one bit per cycle, W = bits of TICK_PERIOD).
// Steps per item, from accept to result registered:
//   plain tick: MUL_P, MOD_INIT, the MOD_ITER loop, DONE
//   PID tick  : MUL_P, MUL_I, MUL_D, ACC, SCALE, SPEED, DIV_INIT,
//               the DIV_ITER loop, DIV_DONE, MOD_INIT, the MOD_ITER loop, DONE
// The next item is taken in the cycle after the result is registered;
// req_ready is low while an item is in work.
// The result sits in an output register; if the receiver stalls, one more item
// is taken and worked up to its final step, which holds until the register
// empties; no further item is taken meanwhile.
// Reset clears gains, counters, error history and sets both speeds to 33.
module line_follow_pid_stepper_pulser #(
   parameter int TICK_PERIOD  = lfpid_pkg::TICK_PERIOD_DEF,
   parameter int UPDATE_EVERY = lfpid_pkg::UPDATE_EVERY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lfpid_pkg::SENSOR_W-1:0]    req_sensor_left,
   input  logic [lfpid_pkg::SENSOR_W-1:0]    req_sensor_center_left,
   input  logic [lfpid_pkg::SENSOR_W-1:0]    req_sensor_center_right,
   input  logic [lfpid_pkg::SENSOR_W-1:0]    req_sensor_right,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_step_left_pulse,
   output logic                              rsp_step_right_pulse,
   output logic [lfpid_pkg::SPEED_W-1:0]     rsp_speed_left_now,
   output logic [lfpid_pkg::SPEED_W-1:0]     rsp_speed_right_now,
   input  logic                              csr_write_en,
   input  logic [lfpid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfpid_pkg::GAIN_W-1:0]      csr_write_data
);

   localparam int CNT_W  = $clog2(TICK_PERIOD + 1);
   localparam int UPD_W  = $clog2(UPDATE_EVERY + 1);
   localparam int DEN_W  = (CNT_W > lfpid_pkg::SPEED_W) ? CNT_W : lfpid_pkg::SPEED_W;
   localparam int ITER_W = $clog2(CNT_W);
   localparam int DIV_RESET_VAL = (TICK_PERIOD / lfpid_pkg::SPEED_CENTER == 0) ? 1 :
                                  TICK_PERIOD / lfpid_pkg::SPEED_CENTER;

   localparam int ERR_W  = lfpid_pkg::ERR_W;
   localparam int SUM_W  = lfpid_pkg::SUM_W;
   localparam int GAIN_W = lfpid_pkg::GAIN_W;
   localparam int PROD_W = lfpid_pkg::PROD_W;
   localparam int ACC_W  = lfpid_pkg::ACC_W;
   localparam int SPD_W  = lfpid_pkg::SPEED_W;
   localparam int Y_W    = lfpid_pkg::Y_W;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   lfpid_pkg::ctrl_type   ctrl;
   lfpid_pkg::status_type status;

   logic req_accept, rsp_accept;

   // configuration and state
   logic signed [GAIN_W-1:0] gain_p_ff, gain_p_in;
   logic signed [GAIN_W-1:0] gain_i_ff, gain_i_in;
   logic signed [GAIN_W-1:0] gain_d_ff, gain_d_in;
   logic [CNT_W-1:0]         tick_ff, tick_in;
   logic [UPD_W-1:0]         upd_ff, upd_in;
   logic signed [ERR_W-1:0]  prev_ff, prev_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SPD_W-1:0]         speed_l_ff, speed_l_in;
   logic [SPD_W-1:0]         speed_r_ff, speed_r_in;
   logic [CNT_W-1:0]         div_l_ff, div_l_in;
   logic [CNT_W-1:0]         div_r_ff, div_r_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [ERR_W-1:0]  e_ff, e_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [Y_W-1:0]           y_ff, y_in;
   logic                     hi_ff, hi_in;
   logic                     lo_ff, lo_in;
   logic                     frac0_ff, frac0_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     pulse_l_ff, pulse_l_in;
   logic                     pulse_r_ff, pulse_r_in;
   logic [SPD_W-1:0]         out_l_ff, out_l_in;
   logic [SPD_W-1:0]         out_r_ff, out_r_in;

   logic signed [15:0]       ext_l, ext_cl, ext_cr, ext_r, e_wide;
   logic signed [ERR_W:0]    diff;
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [SUM_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [SUM_W:0]    sum_wide;
   logic [Y_W+lfpid_pkg::RECIP_W-1:0] q_prod;
   logic [SPD_W-1:0]         q;
   logic [Y_W-1:0]           q5;
   logic                     exact;
   logic [SPD_W-1:0]         sl_raw, sr_raw;

   logic                     lane_load, lane_step;
   logic [CNT_W-1:0]         lane_dividend;
   logic [DEN_W-1:0]         lane_div_l, lane_div_r;
   logic [CNT_W-1:0]         quot_l, quot_r;
   logic [DEN_W-1:0]         rem_l, rem_r;

   logic                     tick_last;

   assign req_ready  = !ctrl.busy;
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid_ff && rsp_ready;

   assign status.start     = req_accept;
   assign status.skip_pid  = (upd_ff != '0);
   assign status.loop_more = (iter_ff != '0);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   lfpid_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // error numerator
   assign ext_l  = {6'd0, req_sensor_left};
   assign ext_cl = {6'd0, req_sensor_center_left};
   assign ext_cr = {6'd0, req_sensor_center_right};
   assign ext_r  = {6'd0, req_sensor_right};
   assign e_wide = ext_l * 16'sd6 + ext_cl * 16'sd5 - ext_cr * 16'sd5 - ext_r * 16'sd6;

   // shared multiplier
   assign diff = (ERR_W+1)'(e_ff) - (ERR_W+1)'(prev_ff);

   always_comb begin
      mul_a = gain_p_ff;
      mul_b = SUM_W'(e_ff);
      case (ctrl.op)
         lfpid_pkg::OP_MUL_I: begin
            mul_a = gain_i_ff;
            mul_b = sum_ff;
         end
         lfpid_pkg::OP_MUL_D: begin
            mul_a = gain_d_ff;
            mul_b = SUM_W'(diff);
         end
         default: begin
            mul_a = gain_p_ff;
            mul_b = SUM_W'(e_ff);
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(e_ff);

   // speed from scaled PID value: floor(y / 5) via reciprocal
   assign q_prod = y_ff * lfpid_pkg::RECIP_W'(lfpid_pkg::RECIP);
   assign q      = q_prod[lfpid_pkg::RECIP_SHIFT +: SPD_W];
   assign q5     = Y_W'(q) * Y_W'(lfpid_pkg::DEN_ODD);
   assign exact  = frac0_ff && (q5 == y_ff);

   always_comb begin
      if (hi_ff) begin
         sl_raw = SPD_W'(lfpid_pkg::SPEED_MAX);
         sr_raw = '0;
      end else if (lo_ff) begin
         sl_raw = '0;
         sr_raw = SPD_W'(lfpid_pkg::SPEED_MAX);
      end else begin
         sl_raw = q;
         sr_raw = exact ? SPD_W'(lfpid_pkg::SPEED_MAX) - q
                        : SPD_W'(lfpid_pkg::SPEED_MAX - 1) - q;
      end
   end

   // divider lanes
   assign lane_load = ctrl.fire && (ctrl.op == lfpid_pkg::OP_DIV_INIT ||
                                    ctrl.op == lfpid_pkg::OP_MOD_INIT);
   assign lane_step = ctrl.fire && (ctrl.op == lfpid_pkg::OP_DIV_ITER ||
                                    ctrl.op == lfpid_pkg::OP_MOD_ITER);

   always_comb begin
      if (ctrl.op == lfpid_pkg::OP_DIV_INIT) begin
         lane_dividend = CNT_W'(TICK_PERIOD);
         lane_div_l    = DEN_W'(speed_l_ff);
         lane_div_r    = DEN_W'(speed_r_ff);
      end else begin
         lane_dividend = tick_ff;
         lane_div_l    = DEN_W'(div_l_ff);
         lane_div_r    = DEN_W'(div_r_ff);
      end
   end

   lfpid_div_lane #(.NUM_W(CNT_W), .DEN_W(DEN_W)) u_lane_l (
      .clock     (clock),
      .load      (lane_load),
      .step      (lane_step),
      .dividend  (lane_dividend),
      .divisor   (lane_div_l),
      .quotient  (quot_l),
      .remainder (rem_l)
   );

   lfpid_div_lane #(.NUM_W(CNT_W), .DEN_W(DEN_W)) u_lane_r (
      .clock     (clock),
      .load      (lane_load),
      .step      (lane_step),
      .dividend  (lane_dividend),
      .divisor   (lane_div_r),
      .quotient  (quot_r),
      .remainder (rem_r)
   );

   assign tick_last = (tick_ff == CNT_W'(TICK_PERIOD - 1));

   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      tick_in      = tick_ff;
      upd_in       = upd_ff;
      prev_in      = prev_ff;
      sum_in       = sum_ff;
      speed_l_in   = speed_l_ff;
      speed_r_in   = speed_r_ff;
      div_l_in     = div_l_ff;
      div_r_in     = div_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      e_in         = e_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      y_in         = y_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      frac0_in     = frac0_ff;
      iter_in      = iter_ff;
      pulse_l_in   = pulse_l_ff;
      pulse_r_in   = pulse_r_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;

      if (csr_write_en) begin
         case (csr_index)
            lfpid_pkg::REG_GAIN_P: gain_p_in = csr_write_data;
            lfpid_pkg::REG_GAIN_I: gain_i_in = csr_write_data;
            lfpid_pkg::REG_GAIN_D: gain_d_in = csr_write_data;
            default: ;
         endcase
      end

      if (req_accept) begin
         e_in = e_wide[ERR_W-1:0];
      end

      if (ctrl.fire) begin
         case (ctrl.op)
            lfpid_pkg::OP_MUL_P: prod_in = mul_p;
            lfpid_pkg::OP_MUL_I: begin
               prod_in = mul_p;
               acc_in  = ACC_W'(prod_ff);
            end
            lfpid_pkg::OP_MUL_D: begin
               prod_in = mul_p;
               acc_in  = acc_ff + ACC_W'(prod_ff);
            end
            lfpid_pkg::OP_ACC: acc_in = acc_ff + ACC_W'(prod_ff);
            lfpid_pkg::OP_SCALE: begin
               y_in     = acc_ff[lfpid_pkg::DEN_SHIFT +: Y_W] + Y_W'(lfpid_pkg::Y_OFFSET);
               hi_in    = acc_ff > lfpid_pkg::ACC_HI;
               lo_in    = acc_ff < lfpid_pkg::ACC_LO;
               frac0_in = (acc_ff[lfpid_pkg::DEN_SHIFT-1:0] == '0);
               prev_in  = e_ff;
               if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                  sum_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
               end else begin
                  sum_in = sum_wide[SUM_W-1:0];
               end
            end
            lfpid_pkg::OP_SPEED: begin
               speed_l_in = (sl_raw == '0) ? SPD_W'(1) : sl_raw;
               speed_r_in = (sr_raw == '0) ? SPD_W'(1) : sr_raw;
            end
            lfpid_pkg::OP_DIV_INIT: iter_in = ITER_W'(CNT_W - 1);
            lfpid_pkg::OP_DIV_ITER: iter_in = iter_ff - ITER_W'(1);
            lfpid_pkg::OP_DIV_DONE: begin
               div_l_in = (quot_l == '0) ? CNT_W'(1) : quot_l;
               div_r_in = (quot_r == '0) ? CNT_W'(1) : quot_r;
            end
            lfpid_pkg::OP_MOD_INIT: iter_in = ITER_W'(CNT_W - 1);
            lfpid_pkg::OP_MOD_ITER: iter_in = iter_ff - ITER_W'(1);
            lfpid_pkg::OP_DONE: begin
               rsp_valid_in = 1'b1;
               pulse_l_in   = (rem_l == '0);
               pulse_r_in   = (rem_r == '0);
               out_l_in     = speed_l_ff;
               out_r_in     = speed_r_ff;
               tick_in      = tick_last ? '0 : tick_ff + CNT_W'(1);
               if (tick_last || upd_ff == UPD_W'(UPDATE_EVERY - 1)) begin
                  upd_in = '0;
               end else begin
                  upd_in = upd_ff + UPD_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         tick_ff      <= '0;
         upd_ff       <= '0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         speed_l_ff   <= SPD_W'(lfpid_pkg::SPEED_CENTER);
         speed_r_ff   <= SPD_W'(lfpid_pkg::SPEED_CENTER);
         div_l_ff     <= CNT_W'(DIV_RESET_VAL);
         div_r_ff     <= CNT_W'(DIV_RESET_VAL);
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         tick_ff      <= tick_in;
         upd_ff       <= upd_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         speed_l_ff   <= speed_l_in;
         speed_r_ff   <= speed_r_in;
         div_l_ff     <= div_l_in;
         div_r_ff     <= div_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      y_ff       <= y_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      frac0_ff   <= frac0_in;
      iter_ff    <= iter_in;
      pulse_l_ff <= pulse_l_in;
      pulse_r_ff <= pulse_r_in;
      out_l_ff   <= out_l_in;
      out_r_ff   <= out_r_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_step_left_pulse  = pulse_l_ff;
   assign rsp_step_right_pulse = pulse_r_ff;
   assign rsp_speed_left_now   = out_l_ff;
   assign rsp_speed_right_now  = out_r_ff;

   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_left_now != '0) && (rsp_speed_right_now != '0))
      else $error("result speed is zero");

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.fire && ctrl.op == lfpid_pkg::OP_DONE))
      else $error("result raised outside final step");

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff < CNT_W'(TICK_PERIOD))
      else $error("tick counter out of range");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.op == lfpid_pkg::OP_MOD_INIT) |-> (div_l_ff != '0) && (div_r_ff != '0))
      else $error("step divisor is zero");

endmodule
